@@ sv/assert_macros.svh @@
// assertion helpers, clocked on clk with asynchronous reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define SDS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition must never be seen at a rising edge out of reset
`define SDS_ASSERT_NEVER(label, cond, msg) \
	`SDS_ASSERT(label, !(cond), msg)

`endif

@@ sv/sds_pkg.sv @@
package sds_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int CYL_BITS    = 16;
	localparam int SEEK_BITS   = 17;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
	localparam int STEP_BITS   = $clog2(SEEK_BITS);
	localparam int TDATA_BITS  = ((3 * CYL_BITS + 2 * SEEK_BITS + 7) / 8) * 8;

	typedef logic [CYL_BITS-1:0]   cyl_t;
	typedef logic [SEEK_BITS-1:0]  seek_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [STEP_BITS-1:0]  step_t;
	typedef logic [TDATA_BITS-1:0] tdata_t;

	// what one cell hands to its upper neighbor
	typedef struct packed {
		logic gt;
		cyl_t val;
	} sds_link_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_MOVE,
		ST_DIV,
		ST_FINAL
	} sds_state_t;

endpackage

@@ sv/scan_disk_scheduler_top.sv @@
// SCAN (elevator) disk scheduler, head sweeping toward cylinder 0 first. Requests
// enter one item per cycle on the s_ side and drop straight into a sorted chain of
// 32 cells; a request arriving with 32 already held is dropped, but its tlast still
// starts service. After the tlast item the block stops taking requests: a scan of
// the chain, one cell per cycle, finds the first request at or above head_start,
// then one move item leaves per cycle while m_tready is high: the requests below
// the head in descending order, the trip to cylinder 0, then the rest in ascending
// order, n+1 items for n requests. Before the final item a bit-serial divider forms
// the average seek. head_start is read when service begins, so it may be rewritten
// between requests.
`include "assert_macros.svh"

module scan_disk_scheduler_top (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration: head_start
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_wdata,
	// requests
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [15:0]             s_tdata,   // request_cylinder
	input  logic                    s_tlast,   // is_last_request
	// head moves
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output sds_pkg::tdata_t         m_tdata,   // move_from, move_to, move_distance,
	                                           // running_seek, average_seek, zero pad
	output logic                    m_tlast    // last_move
);

	sds_pkg::sds_state_t state_q, state_d;

	// control state
	sds_pkg::cyl_t  head_q;
	sds_pkg::cnt_t  count_q;
	sds_pkg::cnt_t  p_q;
	sds_pkg::cnt_t  k_q;
	logic           down_q;
	logic           m_tvalid_q;

	// datapath
	sds_pkg::cyl_t  pos_q;
	sds_pkg::seek_t total_q;
	sds_pkg::cyl_t  pend_from_q;
	sds_pkg::cyl_t  pend_to_q;
	sds_pkg::cyl_t  pend_dist_q;
	sds_pkg::cyl_t  from_q;
	sds_pkg::cyl_t  to_q;
	sds_pkg::cyl_t  dist_q;
	sds_pkg::seek_t run_q;
	sds_pkg::seek_t avg_q;
	logic           m_tlast_q;

	logic           in_acc;
	logic           ins_en;
	logic           out_free;
	sds_pkg::cnt_t  p_m1;
	sds_pkg::idx_t  rd_addr;
	sds_pkg::cyl_t  rd_val;
	logic           below;
	sds_pkg::cyl_t  move_to;
	logic           move_last;
	sds_pkg::cyl_t  move_dist;
	sds_pkg::seek_t new_total;
	logic           emit;
	logic           emit_final;
	logic           div_start;
	logic           div_done;
	sds_pkg::seek_t quotient;

	// sorted request store
	sds_chain u_chain (
		.clk     (clk),
		.ins_en  (ins_en),
		.new_val (s_tdata),
		.count   (count_q),
		.rd_addr (rd_addr),
		.rd_val  (rd_val)
	);

	// average seek = total / request count
	sds_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_total),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// move arithmetic
	always_comb begin
		p_m1     = p_q - 1'b1;
		out_free = !m_tvalid_q || m_tready;
		if (state_q == sds_pkg::ST_SCAN || !down_q) begin
			rd_addr = p_q[sds_pkg::IDX_BITS-1:0];
		end else begin
			rd_addr = p_m1[sds_pkg::IDX_BITS-1:0];
		end
		below = (p_q < count_q) && (rd_val < head_q);
		if (down_q) begin
			move_to   = (p_q != '0) ? rd_val : '0;
			move_last = (p_q == '0) && (k_q == count_q);
		end else begin
			move_to   = rd_val;
			move_last = sds_pkg::cnt_t'(p_q + 1'b1) == count_q;
		end
		move_dist = (pos_q >= move_to) ? (pos_q - move_to) : (move_to - pos_q);
		new_total = total_q + sds_pkg::seek_t'(move_dist);
	end

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		emit       = 1'b0;
		emit_final = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			sds_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = sds_pkg::ST_SCAN;
				end
			end
			sds_pkg::ST_SCAN: begin
				if (!below) begin
					state_d = sds_pkg::ST_MOVE;
				end
			end
			sds_pkg::ST_MOVE: begin
				if (move_last) begin
					div_start = 1'b1;
					state_d   = sds_pkg::ST_DIV;
				end else if (out_free) begin
					emit = 1'b1;
				end
			end
			sds_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sds_pkg::ST_FINAL;
				end
			end
			sds_pkg::ST_FINAL: begin
				if (out_free) begin
					emit_final = 1'b1;
					state_d    = sds_pkg::ST_LOAD;
				end
			end
			default: state_d = sds_pkg::ST_LOAD;
		endcase
		in_acc = s_tvalid && s_tready;
		// a full store drops the request
		ins_en = in_acc && (count_q != sds_pkg::cnt_t'(sds_pkg::QUEUE_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sds_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			p_q        <= '0;
			k_q        <= '0;
			down_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				head_q <= cfg_wdata;
			end
			if (ins_en) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				sds_pkg::ST_LOAD: begin
					if (in_acc && s_tlast) begin
						p_q <= '0;
					end
				end
				sds_pkg::ST_SCAN: begin
					if (below) begin
						p_q <= p_q + 1'b1;
					end else begin
						// split point found, start the downward sweep there
						k_q    <= p_q;
						down_q <= 1'b1;
					end
				end
				sds_pkg::ST_MOVE: begin
					if (emit) begin
						if (!down_q) begin
							p_q <= p_q + 1'b1;
						end else if (p_q != '0) begin
							p_q <= p_m1;
						end else begin
							// just went to cylinder 0, turn around
							down_q <= 1'b0;
							p_q    <= k_q;
						end
					end
				end
				sds_pkg::ST_FINAL: begin
					if (emit_final) begin
						count_q <= '0;
					end
				end
				default: ;
			endcase
			if (emit || emit_final) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// head position, totals and the output item
	always_ff @(posedge clk) begin
		if (state_q == sds_pkg::ST_SCAN && !below) begin
			pos_q   <= head_q;
			total_q <= '0;
		end
		if (state_q == sds_pkg::ST_MOVE) begin
			if (move_last) begin
				// hold the final move until the average is ready
				pend_from_q <= pos_q;
				pend_to_q   <= move_to;
				pend_dist_q <= move_dist;
				total_q     <= new_total;
			end else if (emit) begin
				pos_q     <= move_to;
				total_q   <= new_total;
				from_q    <= pos_q;
				to_q      <= move_to;
				dist_q    <= move_dist;
				run_q     <= new_total;
				avg_q     <= '0;
				m_tlast_q <= 1'b0;
			end
		end
		if (emit_final) begin
			from_q    <= pend_from_q;
			to_q      <= pend_to_q;
			dist_q    <= pend_dist_q;
			run_q     <= total_q;
			avg_q     <= quotient;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = sds_pkg::tdata_t'({avg_q, run_q, dist_q, to_q, from_q});

	`SDS_ASSERT(a_count_bound, count_q <= sds_pkg::cnt_t'(sds_pkg::QUEUE_DEPTH), "request count beyond store depth")
	`SDS_ASSERT(a_ptr_bound, (state_q == sds_pkg::ST_MOVE) |-> (p_q <= count_q), "sweep pointer beyond stored requests")
	`SDS_ASSERT_NEVER(a_avg_nonfinal, m_tvalid_q && !m_tlast_q && (avg_q != '0), "average seek set on a non-final move")
	`SDS_ASSERT(a_div_done_state, div_done |-> (state_q == sds_pkg::ST_DIV), "divider finished outside the wait state")

endmodule

@@ sv/sds_cell.sv @@
// one slot of the sorted insertion chain
module sds_cell (
	input  logic                clk,
	input  logic                ins_en,
	input  logic                occ,
	input  sds_pkg::cyl_t       new_val,
	input  sds_pkg::sds_link_t  prev,
	output sds_pkg::sds_link_t  link
);

	sds_pkg::cyl_t val_q;

	// empty slots count as larger than anything
	assign link.gt  = !occ || (val_q > new_val);
	assign link.val = val_q;

	always_ff @(posedge clk) begin
		if (ins_en && link.gt) begin
			val_q <= prev.gt ? prev.val : new_val;
		end
	end

endmodule

@@ sv/sds_chain.sv @@
// row of cells kept in ascending order, one insertion per cycle
module sds_chain (
	input  logic           clk,
	input  logic           ins_en,
	input  sds_pkg::cyl_t  new_val,
	input  sds_pkg::cnt_t  count,
	input  sds_pkg::idx_t  rd_addr,
	output sds_pkg::cyl_t  rd_val
);

	sds_pkg::sds_link_t links      [sds_pkg::QUEUE_DEPTH];
	sds_pkg::sds_link_t prev_links [sds_pkg::QUEUE_DEPTH];

	assign prev_links[0] = '0;

	for (genvar i = 0; i < sds_pkg::QUEUE_DEPTH; i++) begin : g_cell
		if (i > 0) begin : g_prev
			assign prev_links[i] = links[i-1];
		end
		sds_cell u_cell (
			.clk     (clk),
			.ins_en  (ins_en),
			.occ     (sds_pkg::cnt_t'(i) < count),
			.new_val (new_val),
			.prev    (prev_links[i]),
			.link    (links[i])
		);
	end

	assign rd_val = links[rd_addr].val;

endmodule

@@ sv/sds_divider.sv @@
// restoring divider, one quotient bit per cycle
module sds_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sds_pkg::seek_t  dividend,
	input  sds_pkg::cnt_t   divisor,
	output logic            done,
	output sds_pkg::seek_t  quotient
);

	logic                    busy_q;
	logic                    done_q;
	sds_pkg::step_t          step_q;
	sds_pkg::cnt_t           rem_q;
	sds_pkg::cnt_t           div_q;
	sds_pkg::seek_t          quo_q;
	logic [sds_pkg::CNT_BITS:0] trial;
	logic [sds_pkg::CNT_BITS:0] diff;
	logic                    fits;

	always_comb begin
		trial = {rem_q, quo_q[sds_pkg::SEEK_BITS-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= sds_pkg::step_t'(sds_pkg::SEEK_BITS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[sds_pkg::CNT_BITS-1:0] : trial[sds_pkg::CNT_BITS-1:0];
			quo_q <= {quo_q[sds_pkg::SEEK_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
